// ----- design/mff_pkg.sv -----
package mff_pkg;

	// data format of every field
	localparam int DW = 32;
	localparam int FW = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MS_W       = 31;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCALE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_DISTANCE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MANNING_SQUARED = 2'd2;
	localparam logic [CFG_DATA_W-1:0] CD_RESET = 32'h0001_0000;

	// derived pipeline geometry
	localparam int CBRT_W      = (DW - 1 + 2 * FW + 2) / 3;
	localparam int ROOT_STAGES = (DW > CBRT_W) ? DW : CBRT_W;
	localparam int QUO_W       = DW + 1;
	localparam int PIPE_DEPTH  = 2 + ROOT_STAGES + 4 + QUO_W + 1;

	typedef struct packed {
		logic signed [DW-1:0] depth;
		logic signed [DW-1:0] vel_x;
		logic signed [DW-1:0] vel_y;
		logic signed [DW-1:0] force_in;
		logic                 last_cell;
	} in_item_t;

	typedef struct packed {
		logic signed [DW-1:0] force_out;
		logic                 last_cell_out;
	} out_item_t;

endpackage

// ----- design/manning_friction_force.sv -----
// Manning bed friction: force_out = force_in - factor*u*sqrt(u^2+v^2)/cbrt(h),
// factor = force_scale * cell_distance * manning_squared; signed Q16.16, manning_squared unsigned Q15.16.
// Input channel in_valid/in_stall/in_item, output channel out_valid/out_stall/
// out_item; an item moves on an edge with valid high and stall low.
// Configuration: cfg_we/cfg_idx/cfg_wdata, written while no item is in flight;
// the factor settles in fprod_q, then fm_q, before any new item needs it.
// The stages are squares and sum, 32 square root steps that run beside the
// 21 cube root steps, products and overflow check, 33 quotient steps and one
// output stage. Throughput is one item per cycle while no result waits on
// out_stall; every stage holds one item.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// A cell with depth not positive passes force_in through unchanged.
// Reset clears all valid bits and loads the register reset values
// (force_scale 0, cell_distance 1.0, manning_squared 0).
module manning_friction_force
	import mff_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int W   = DW;
	localparam int F   = FW;
	localparam int SXW = 2 * W;
	localparam int CN  = CBRT_W;
	localparam int CXW = 3 * CN;
	localparam int RS  = ROOT_STAGES;
	localparam int PW  = 2 * W - 1;
	localparam int NW  = 3 * W;
	localparam int N2W = NW - F;
	localparam int QW  = QUO_W;
	localparam int NST = PIPE_DEPTH;
	localparam logic [W-2:0] CAP = '1;

	typedef struct packed {
		logic [W-1:0] ua;
		logic [W-1:0] f;
		logic         last;
		logic         negu;
		logic         hpos;
	} carry_t;

	// configuration registers
	logic [CFG_DATA_W-1:0] fs_q, cd_q;
	logic [MS_W-1:0]       ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= '0;
			cd_q <= CD_RESET;
			ms_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FORCE_SCALE:     fs_q <= cfg_wdata;
				CFG_CELL_DISTANCE:   cd_q <= cfg_wdata;
				CFG_MANNING_SQUARED: ms_q <= cfg_wdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// factor magnitude, two registered multiplies
	logic [CFG_DATA_W-1:0]   fs_mag, cd_mag;
	logic [2*CFG_DATA_W-1:0] fprod_q;
	logic [2*CFG_DATA_W-F-1:0] fprod_sh;
	logic [W-2:0]            fm1, fm_q;
	logic [W-2+MS_W:0]       fprod2;
	logic [W-2+MS_W-F:0]     fprod2_sh;
	logic                    fneg;

	assign fs_mag = fs_q[CFG_DATA_W-1] ? (~fs_q + 1'b1) : fs_q;
	assign cd_mag = cd_q[CFG_DATA_W-1] ? (~cd_q + 1'b1) : cd_q;
	assign fneg   = fs_q[CFG_DATA_W-1] ^ cd_q[CFG_DATA_W-1];
	assign fprod_sh  = fprod_q[2*CFG_DATA_W-1:F];
	assign fm1       = (fprod_sh > (2*CFG_DATA_W-F)'(CAP)) ? CAP : fprod_sh[W-2:0];
	assign fprod2    = (W-1+MS_W)'(fm1) * (W-1+MS_W)'(ms_q);
	assign fprod2_sh = fprod2[W-2+MS_W:F];

	always_ff @(posedge clk) begin
		fprod_q <= (2*CFG_DATA_W)'(fs_mag) * (2*CFG_DATA_W)'(cd_mag);
		fm_q    <= (fprod2_sh > (W-1+MS_W-F)'(CAP)) ? CAP : fprod2_sh[W-2:0];
	end

	// pipeline advance and valid bits
	logic [NST-1:0] pv_q;
	logic           adv;

	assign adv       = !(pv_q[NST-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = pv_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
		end else if (adv) begin
			pv_q <= {pv_q[NST-2:0], in_valid};
		end
	end

	// stage 1: squares and cube root radicand
	logic [W-1:0]   ua_in, va_in;
	logic           hpos_in;
	logic [SXW-1:0] ua2_s1, va2_s1;
	logic [CXW-1:0] cx_s1;
	carry_t         c_s1;

	assign ua_in   = in_item.vel_x[W-1] ? (~in_item.vel_x + 1'b1) : in_item.vel_x;
	assign va_in   = in_item.vel_y[W-1] ? (~in_item.vel_y + 1'b1) : in_item.vel_y;
	assign hpos_in = !in_item.depth[W-1] && (in_item.depth != '0);

	always_ff @(posedge clk) begin
		if (adv) begin
			ua2_s1 <= SXW'(ua_in) * SXW'(ua_in);
			va2_s1 <= SXW'(va_in) * SXW'(va_in);
			cx_s1  <= hpos_in ? (CXW'(unsigned'(in_item.depth)) << (2 * F)) : '0;
			c_s1   <= '{ua: ua_in, f: in_item.force_in, last: in_item.last_cell,
				negu: in_item.vel_x[W-1], hpos: hpos_in};
		end
	end

	// stage 2: sum of squares
	logic [SXW-1:0] sum_s2;
	logic [CXW-1:0] cx_s2;
	carry_t         c_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= ua2_s1 + va2_s1;
			cx_s2  <= cx_s1;
			c_s2   <= c_s1;
		end
	end

	// root stages: one square root bit per stage, one cube root bit in each of the first CBRT_W stages
	logic [SXW-1:0] sqx_s [0:RS];
	logic [W-1:0]   sqy_s [0:RS];
	logic [CXW-1:0] cbx_s [0:RS];
	logic [CN-1:0]  cby_s [0:RS];
	carry_t         rc_s  [0:RS];

	assign sqx_s[0] = sum_s2;
	assign sqy_s[0] = '0;
	assign cbx_s[0] = cx_s2;
	assign cby_s[0] = '0;
	assign rc_s[0]  = c_s2;

	for (genvar k = 0; k < RS; k++) begin : g_root
		always_ff @(posedge clk) begin
			if (adv) begin
				rc_s[k+1] <= rc_s[k];
			end
		end

		if (k < W) begin : g_sq
			localparam int SS = 2 * (W - 1 - k);
			logic [W-1:0]   y2;
			logic [SXW-1:0] t;
			logic           take;

			assign y2   = {sqy_s[k][W-2:0], 1'b0};
			assign t    = SXW'({y2, 1'b1});
			assign take = (sqx_s[k] >> SS) >= t;

			always_ff @(posedge clk) begin
				if (adv) begin
					sqx_s[k+1] <= take ? (sqx_s[k] - (t << SS)) : sqx_s[k];
					sqy_s[k+1] <= take ? {y2[W-1:1], 1'b1} : y2;
				end
			end
		end else begin : g_sq_pass
			always_ff @(posedge clk) begin
				if (adv) begin
					sqx_s[k+1] <= sqx_s[k];
					sqy_s[k+1] <= sqy_s[k];
				end
			end
		end

		if (k < CN) begin : g_cb
			localparam int CS = 3 * (CN - 1 - k);
			logic [CN-1:0]     y2;
			logic [2*CN+1:0]   m;
			logic [2*CN+1:0]   t;
			logic [CXW-1:0]    tx;
			logic              take;

			assign y2   = {cby_s[k][CN-2:0], 1'b0};
			assign m    = (2*CN+2)'(y2) * (2*CN+2)'({1'b0, y2} + 1'b1);
			assign t    = m + (m << 1) + 1'b1;
			assign tx   = CXW'(t);
			assign take = (cbx_s[k] >> CS) >= tx;

			always_ff @(posedge clk) begin
				if (adv) begin
					cbx_s[k+1] <= take ? (cbx_s[k] - (tx << CS)) : cbx_s[k];
					cby_s[k+1] <= take ? {y2[CN-1:1], 1'b1} : y2;
				end
			end
		end else begin : g_cb_pass
			always_ff @(posedge clk) begin
				if (adv) begin
					cbx_s[k+1] <= cbx_s[k];
					cby_s[k+1] <= cby_s[k];
				end
			end
		end
	end

	// product stages: factor times |u|, then times speed in two halves
	logic [PW-1:0]    p1_m1;
	logic [W-1:0]     sp_m1;
	logic [CN-1:0]    cr_m1, cr_m2, cr_m3;
	carry_t           c_m1, c_m2, c_m3;
	logic [2*W-1:0]   pl_m2;
	logic [2*W-2:0]   ph_m2;
	logic [NW-1:0]    num;
	logic [N2W-1:0]   n2_m3;

	assign num = NW'(pl_m2) + (NW'(ph_m2) << W);

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_m1 <= PW'(fm_q) * PW'(rc_s[RS].ua);
			sp_m1 <= sqy_s[RS];
			cr_m1 <= cby_s[RS];
			c_m1  <= rc_s[RS];
			pl_m2 <= (2*W)'(p1_m1[W-1:0]) * (2*W)'(sp_m1);
			ph_m2 <= (2*W-1)'(p1_m1[PW-1:W]) * (2*W-1)'(sp_m1);
			cr_m2 <= cr_m1;
			c_m2  <= c_m1;
			n2_m3 <= num[NW-1:F];
			cr_m3 <= cr_m2;
			c_m3  <= c_m2;
		end
	end

	// quotient stages: overflow check, then one quotient bit per stage
	logic [CN-1:0] dr_s   [0:QW];
	logic [QW-1:0] dn_s   [0:QW];
	logic [QW-1:0] dq_s   [0:QW];
	logic [CN-1:0] dc_s   [0:QW];
	logic          dovf_s [0:QW];
	carry_t        dctl_s [0:QW];

	always_ff @(posedge clk) begin
		if (adv) begin
			dovf_s[0] <= n2_m3[N2W-1:QW] >= (N2W-QW)'(cr_m3);
			dr_s[0]   <= n2_m3[QW+CN-1:QW];
			dn_s[0]   <= n2_m3[QW-1:0];
			dq_s[0]   <= '0;
			dc_s[0]   <= cr_m3;
			dctl_s[0] <= c_m3;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [CN:0] rr;
		logic        ge;

		assign rr = {dr_s[j], dn_s[j][QW-1]};
		assign ge = rr >= {1'b0, dc_s[j]};

		always_ff @(posedge clk) begin
			if (adv) begin
				dr_s[j+1]   <= ge ? CN'(rr - {1'b0, dc_s[j]}) : rr[CN-1:0];
				dn_s[j+1]   <= {dn_s[j][QW-2:0], 1'b0};
				dq_s[j+1]   <= {dq_s[j][QW-2:0], ge};
				dc_s[j+1]   <= dc_s[j];
				dovf_s[j+1] <= dovf_s[j];
				dctl_s[j+1] <= dctl_s[j];
			end
		end
	end

	// output stage: cap the term, apply its sign, saturate
	localparam logic [QW-1:0] QMAX = {1'b1, {W{1'b0}}};
	logic [QW-1:0]          qcap;
	logic                   neg;
	logic signed [W+1:0]    fx, qx, rsum;
	logic [W-1:0]           res;
	carry_t                 fc;
	out_item_t              out_q;

	assign fc   = dctl_s[QW];
	assign qcap = (dovf_s[QW] || dq_s[QW] > QMAX) ? QMAX : dq_s[QW];
	assign neg  = fneg ^ fc.negu;
	assign fx   = {{2{fc.f[W-1]}}, fc.f};
	assign qx   = {1'b0, qcap};
	assign rsum = neg ? (fx + qx) : (fx - qx);

	always_comb begin
		if (!fc.hpos) begin
			res = fc.f;
		end else if (rsum[W+1] && (rsum[W:W-1] != 2'b11)) begin
			res = {1'b1, {(W-1){1'b0}}};
		end else if (!rsum[W+1] && (rsum[W:W-1] != 2'b00)) begin
			res = {1'b0, {(W-1){1'b1}}};
		end else begin
			res = rsum[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= '{force_out: res, last_cell_out: fc.last};
		end
	end

	assign out_item = out_q;

endmodule

// ----- design/mff_checker.sv -----
module mff_checker
	import mff_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// items in flight, from the ports alone
	logic [7:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 8'(in_acc) - 8'(out_acc);
		end
	end

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// input is held back only by a waiting result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back pressure");

	// no result without an item inside
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 8'd0)
		else $error("result with no item in flight");

	// in-flight count stays within the pipeline depth
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 8'(PIPE_DEPTH))
		else $error("more items in flight than stages");

endmodule

bind manning_friction_force mff_checker u_mff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
